>>> hw/rtl/prca_pkg.sv
// Shared types and codes for the page reserve and commit allocator.
// Holds the page entry layout, the request and result records and the sequencer states.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package prca_pkg;

	// Operation codes carried by the mode field
	localparam logic [2:0] MODE_ALLOC   = 3'd0;
	localparam logic [2:0] MODE_FIXED   = 3'd1;
	localparam logic [2:0] MODE_DECOMIT = 3'd2;
	localparam logic [2:0] MODE_RELEASE = 3'd3;
	localparam logic [2:0] MODE_QUERY   = 3'd4;
	localparam logic [2:0] MODE_SIZE    = 3'd5;

	// Page status codes
	localparam logic [1:0] PG_FREE      = 2'd0;
	localparam logic [1:0] PG_RESERVED  = 2'd1;
	localparam logic [1:0] PG_COMMITTED = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
	localparam logic [1:0] CFG_PAGE_SHIFT = 2'd1;
	localparam logic [1:0] CFG_MIN_ALIGN = 2'd2;

	// Page size limits applied to the page shift register
	localparam logic [4:0] PS_MIN = 5'd12;
	localparam logic [4:0] PS_MAX = 5'd16;

	typedef struct packed {
		logic [31:0] heap_base;
		logic [4:0]  page_shift;
		logic [4:0]  min_align;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] base;
		logic [31:0] prot;
	} page_ent_t;

	typedef struct packed {
		logic        we_a;
		logic        we_b;
		page_ent_t   wd_a;
	} tbl_wr_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] address;
		logic [31:0] byte_count;
		logic [4:0]  align_shift;
		logic        do_commit;
		logic        top_down;
		logic        do_reserve;
		logic [31:0] protect_flags;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] addr;
		logic [31:0] bytes;
		logic [31:0] abase;
		logic [31:0] aprot;
		logic [1:0]  st;
		logic [31:0] prot;
		logic        wc;
	} result_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_FIT,
		S_WRD,
		S_WEV,
		S_MARK,
		S_MRD,
		S_MEV,
		S_FRD,
		S_FEV,
		S_FDEC,
		S_PRD,
		S_PEV,
		S_QRD,
		S_QEV,
		S_QAB,
		S_ARD,
		S_AEV,
		S_DONE
	} seq_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/prca_table.sv
// Page table storage: entry memory (status, base, protection) and run length memory.
// Both memories share one address and have a registered read.
// Depends on prca_pkg.
`default_nettype none

module prca_table #(
	parameter int NUM_PAGES = 4096
) (
	input  wire logic                               clk,
	input  wire logic [$clog2(NUM_PAGES)-1:0]       addr,
	input  wire prca_pkg::tbl_wr_t                  wr,
	input  wire logic [$clog2(NUM_PAGES+1)-1:0]     wd_b,
	output prca_pkg::page_ent_t                     rd_a,
	output logic [$clog2(NUM_PAGES+1)-1:0]          rd_b
);
	import prca_pkg::*;

	localparam int CW = $clog2(NUM_PAGES + 1);

	page_ent_t       mem_a [NUM_PAGES];
	logic [CW-1:0]   mem_b [NUM_PAGES];

	always_ff @(posedge clk) begin
		if (wr.we_a) begin
			mem_a[addr] <= wr.wd_a;
		end
		rd_a <= mem_a[addr];
	end

	always_ff @(posedge clk) begin
		if (wr.we_b) begin
			mem_b[addr] <= wd_b;
		end
		rd_b <= mem_b[addr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/prca_seq.sv
// Operation sequencer: walks the page table one entry at a time for every operation.
// Reads, modifies and writes back entries, keeps the next-fit hint and builds the result.
// Depends on prca_pkg; drives the memories in prca_table.
`default_nettype none

module prca_seq #(
	parameter int NUM_PAGES = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire prca_pkg::cfg_t                     cfg,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire prca_pkg::req_t                     req,
	output logic                                    res_valid,
	input  wire logic                               res_ready,
	output prca_pkg::result_t                       res,
	output logic [$clog2(NUM_PAGES)-1:0]            tbl_addr,
	output prca_pkg::tbl_wr_t                       tbl_wr,
	output logic [$clog2(NUM_PAGES+1)-1:0]          tbl_wd_b,
	input  wire prca_pkg::page_ent_t                tbl_rd_a,
	input  wire logic [$clog2(NUM_PAGES+1)-1:0]     tbl_rd_b
);
	import prca_pkg::*;

	localparam int AW = $clog2(NUM_PAGES);
	localparam int CW = $clog2(NUM_PAGES + 1);
	// Slot positions must hold aligned values up to the largest alignment in pages.
	localparam int XW = CW + 20;
	localparam int KW = 34;
	localparam logic [XW-1:0] NX  = XW'(NUM_PAGES);
	localparam logic [KW-1:0] NK  = KW'(NUM_PAGES);
	localparam logic [31:0]   N32 = 32'(NUM_PAGES);

	seq_state_t      state_q, state_d;
	req_t            req_q;
	result_t         res_q;
	page_ent_t       qent_q;
	logic [XW-1:0]   cur_q, base_q, end_q;
	logic [CW-1:0]   cnt_q, hint_q;
	logic            pass_q, mk_rel_q, rmw_com_q;
	logic            used_q, free_q, notc_q;

	logic [4:0]      ps, al_min, al, as;
	logic [31:0]     psz_m1, off, pg_off, aoff, apg;
	logic [XW-1:0]   ap_x, first_x, i0, step_x, rem_x, rc_x;
	logic [KW-1:0]   cnt_al, cnt_fx, rem_k, dc;
	logic            inh, ainh, al_bad, fx_bad, fit_over, nf_retry, step_end;
	logic            pg_used, td_stop, rel_bad, q_match, q_more, ab_look;

	function automatic logic [XW-1:0] align_up(logic [XW-1:0] x, logic [4:0] s);
		logic [XW-1:0] m;
		m = (XW'(1) << s) - XW'(1);
		return (x + m) & ~m;
	endfunction

	function automatic logic [31:0] pg_addr(logic [31:0] hb, logic [XW-1:0] i,
			logic [4:0] sh);
		return hb + (32'(i) << sh);
	endfunction

	// Effective page size and alignment in pages
	always_comb begin
		if (cfg.page_shift < PS_MIN) begin
			ps = PS_MIN;
		end else if (cfg.page_shift > PS_MAX) begin
			ps = PS_MAX;
		end else begin
			ps = cfg.page_shift;
		end
		al_min = (cfg.min_align > ps) ? cfg.min_align : ps;
		al     = (req_q.align_shift > al_min) ? req_q.align_shift : al_min;
		as     = al - ps;
	end

	assign ap_x    = XW'(1) << as;
	assign psz_m1  = (32'd1 << ps) - 32'd1;
	assign off     = req_q.address - cfg.heap_base;
	assign pg_off  = off >> ps;
	assign inh     = (req_q.address >= cfg.heap_base) && (pg_off < N32);
	assign first_x = XW'(pg_off);
	assign cnt_al  = KW'(req_q.byte_count >> ps) + KW'(|(req_q.byte_count & psz_m1));
	assign cnt_fx  = (KW'(off & psz_m1) + KW'(req_q.byte_count) + KW'(psz_m1)) >> ps;
	assign rem_k   = NK - KW'(pg_off);
	assign dc      = (cnt_al > rem_k) ? rem_k : cnt_al;
	assign i0      = XW'(NK - cnt_al) & ~(ap_x - XW'(1));
	assign al_bad  = (req_q.byte_count == 32'd0) || (cnt_al > NK);
	assign fx_bad  = !inh || (req_q.byte_count == 32'd0) || ((KW'(pg_off) + cnt_fx) > NK);

	assign step_x   = cur_q + XW'(1);
	assign step_end = (step_x == end_q);
	assign fit_over = (cur_q + XW'(cnt_q)) > NX;
	assign nf_retry = !pass_q && (hint_q != '0);
	assign pg_used  = (tbl_rd_a.st != PG_FREE);
	assign td_stop  = (base_q < ap_x);
	assign rem_x    = NX - cur_q;
	assign rc_x     = (XW'(tbl_rd_b) > rem_x) ? rem_x : XW'(tbl_rd_b);
	assign rel_bad  = (tbl_rd_b == '0) ||
		(tbl_rd_a.base != pg_addr(cfg.heap_base, cur_q, ps));
	assign q_match  = (tbl_rd_a == qent_q);
	assign q_more   = (step_x < NX);
	assign aoff     = qent_q.base - cfg.heap_base;
	assign apg      = aoff >> ps;
	assign ainh     = (qent_q.base >= cfg.heap_base) && (apg < N32);
	assign ab_look  = (qent_q.base != 32'd0) && ainh;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (cur_q == NX - XW'(1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_PREP;
			end
			S_PREP: begin
				case (req_q.mode)
					MODE_ALLOC: begin
						if (al_bad) state_d = S_DONE;
						else if (req_q.top_down) state_d = S_WRD;
						else state_d = S_FIT;
					end
					MODE_FIXED: begin
						state_d = fx_bad ? S_DONE : S_FRD;
					end
					MODE_DECOMIT: begin
						state_d = (!inh || dc == '0) ? S_DONE : S_MRD;
					end
					MODE_RELEASE, MODE_QUERY, MODE_SIZE: begin
						state_d = inh ? S_PRD : S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FIT: begin
				if (fit_over) state_d = nf_retry ? S_FIT : S_DONE;
				else state_d = S_WRD;
			end
			S_WRD: state_d = S_WEV;
			S_WEV: begin
				if (pg_used) begin
					if (req_q.top_down) state_d = td_stop ? S_DONE : S_WRD;
					else state_d = S_FIT;
				end else begin
					state_d = step_end ? S_MARK : S_WRD;
				end
			end
			S_MARK: begin
				if (step_end) state_d = S_DONE;
			end
			S_MRD: state_d = S_MEV;
			S_MEV: state_d = step_end ? S_DONE : S_MRD;
			S_FRD: state_d = S_FEV;
			S_FEV: state_d = step_end ? S_FDEC : S_FRD;
			S_FDEC: begin
				if (!used_q) state_d = req_q.do_reserve ? S_MARK : S_DONE;
				else if (free_q) state_d = S_DONE;
				else state_d = req_q.do_commit ? S_MRD : S_DONE;
			end
			S_PRD: state_d = S_PEV;
			S_PEV: begin
				case (req_q.mode)
					MODE_RELEASE: state_d = rel_bad ? S_DONE : S_MARK;
					MODE_QUERY:   state_d = q_more ? S_QRD : S_QAB;
					default:      state_d = S_DONE;
				endcase
			end
			S_QRD: state_d = S_QEV;
			S_QEV: state_d = (q_match && q_more) ? S_QRD : S_QAB;
			S_QAB: state_d = ab_look ? S_ARD : S_DONE;
			S_ARD: state_d = S_AEV;
			S_AEV: state_d = S_DONE;
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs and memory write controls
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		res_valid = (state_q == S_DONE);
		res       = res_q;
		tbl_addr  = cur_q[AW-1:0];
		tbl_wr    = '0;
		tbl_wd_b  = '0;
		case (state_q)
			S_CLEAR: begin
				tbl_wr.we_a = 1'b1;
				tbl_wr.we_b = 1'b1;
			end
			S_MARK: begin
				tbl_wr.we_a = 1'b1;
				tbl_wr.we_b = (cur_q == base_q);
				if (!mk_rel_q) begin
					tbl_wr.wd_a.st   = req_q.do_commit ? PG_COMMITTED : PG_RESERVED;
					tbl_wr.wd_a.base = pg_addr(cfg.heap_base, base_q, ps);
					tbl_wr.wd_a.prot = req_q.protect_flags;
					tbl_wd_b         = cnt_q;
				end
			end
			S_MEV: begin
				tbl_wr.we_a = 1'b1;
				tbl_wr.wd_a = tbl_rd_a;
				if (rmw_com_q) begin
					tbl_wr.wd_a.st   = PG_COMMITTED;
					tbl_wr.wd_a.prot = req_q.protect_flags;
				end else if (tbl_rd_a.st == PG_COMMITTED) begin
					tbl_wr.wd_a.st = PG_RESERVED;
				end
			end
			default: begin
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cur_q     <= '0;
			hint_q    <= '0;
			base_q    <= '0;
			end_q     <= '0;
			cnt_q     <= '0;
			pass_q    <= 1'b0;
			mk_rel_q  <= 1'b0;
			rmw_com_q <= 1'b0;
			used_q    <= 1'b0;
			free_q    <= 1'b0;
			notc_q    <= 1'b0;
			req_q     <= '0;
			res_q     <= '0;
			qent_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: cur_q <= step_x;
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req;
						res_q <= '0;
					end
				end
				S_PREP: begin
					case (req_q.mode)
						MODE_ALLOC: begin
							cnt_q  <= CW'(cnt_al);
							pass_q <= 1'b0;
							if (req_q.top_down) begin
								cur_q  <= i0;
								base_q <= i0;
								end_q  <= i0 + XW'(cnt_al);
							end else begin
								cur_q <= align_up(XW'(hint_q), as);
							end
						end
						MODE_FIXED: begin
							cnt_q  <= CW'(cnt_fx);
							cur_q  <= first_x;
							base_q <= first_x;
							end_q  <= first_x + XW'(cnt_fx);
							used_q <= 1'b0;
							free_q <= 1'b0;
							notc_q <= 1'b0;
						end
						MODE_DECOMIT: begin
							res_q.ok  <= inh;
							cur_q     <= first_x;
							end_q     <= first_x + XW'(dc);
							rmw_com_q <= 1'b0;
						end
						default: begin
							cur_q  <= first_x;
							base_q <= first_x;
						end
					endcase
				end
				S_FIT: begin
					if (fit_over) begin
						if (nf_retry) begin
							pass_q <= 1'b1;
							cur_q  <= '0;
						end
					end else begin
						base_q <= cur_q;
						end_q  <= cur_q + XW'(cnt_q);
					end
				end
				S_WEV: begin
					if (pg_used) begin
						if (req_q.top_down) begin
							if (!td_stop) begin
								base_q <= base_q - ap_x;
								cur_q  <= base_q - ap_x;
								end_q  <= base_q - ap_x + XW'(cnt_q);
							end
						end else begin
							cur_q <= align_up(step_x, as);
						end
					end else if (step_end) begin
						cur_q    <= base_q;
						mk_rel_q <= 1'b0;
					end else begin
						cur_q <= step_x;
					end
				end
				S_MARK: begin
					cur_q <= step_x;
					if (step_end && !mk_rel_q) begin
						res_q.ok <= 1'b1;
						if (req_q.mode == MODE_ALLOC) begin
							res_q.addr <= pg_addr(cfg.heap_base, base_q, ps);
							if (!req_q.top_down) hint_q <= CW'(end_q);
						end
					end
				end
				S_MEV: begin
					cur_q <= step_x;
					if (step_end) res_q.ok <= 1'b1;
				end
				S_FEV: begin
					cur_q <= step_x;
					if (tbl_rd_a.st != PG_FREE) used_q <= 1'b1;
					if (tbl_rd_a.st == PG_FREE) free_q <= 1'b1;
					if (tbl_rd_a.st != PG_COMMITTED) notc_q <= 1'b1;
				end
				S_FDEC: begin
					res_q.wc  <= !notc_q;
					cur_q     <= base_q;
					mk_rel_q  <= 1'b0;
					rmw_com_q <= 1'b1;
					if (used_q && !free_q && !req_q.do_commit) res_q.ok <= 1'b1;
				end
				S_PEV: begin
					case (req_q.mode)
						MODE_RELEASE: begin
							if (!rel_bad) begin
								res_q.ok    <= 1'b1;
								res_q.bytes <= 32'(rc_x) << ps;
								end_q       <= cur_q + rc_x;
								mk_rel_q    <= 1'b1;
							end
						end
						MODE_SIZE: begin
							if (tbl_rd_a.base == req_q.address) begin
								res_q.bytes <= 32'(tbl_rd_b) << ps;
								res_q.ok    <= ((32'(tbl_rd_b) << ps) != 32'd0);
							end
						end
						MODE_QUERY: begin
							qent_q      <= tbl_rd_a;
							res_q.ok    <= 1'b1;
							res_q.addr  <= pg_addr(cfg.heap_base, cur_q, ps);
							res_q.abase <= tbl_rd_a.base;
							res_q.st    <= tbl_rd_a.st;
							res_q.prot  <= tbl_rd_a.prot;
							cur_q       <= step_x;
						end
						default: begin
						end
					endcase
				end
				S_QEV: begin
					if (q_match) cur_q <= step_x;
				end
				S_QAB: begin
					res_q.bytes <= 32'(cur_q - base_q) << ps;
					if (ab_look) cur_q <= XW'(apg);
				end
				S_AEV: res_q.aprot <= tbl_rd_a.prot;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/page_reserve_commit_allocator_core.sv
// Page reserve and commit allocator: one operation at a time over a page table kept in
// block memory. After reset the table is cleared entry by entry, during which no
// item is taken (configuration writes still are). An operation then goes through a
// set-up state and the page walk of its mode: the searches and scans read each entry
// and then evaluate it, reserve and release marking write one page a cycle, commit and
// decommit read each page and then write it back, and a query reads and compares each
// page of its run of like pages in turn. The finished result waits in an output
// register, so the next item can be taken while it is still unclaimed.
// Depends on prca_pkg, prca_table and prca_seq.
`default_nettype none

module page_reserve_commit_allocator_core #(
	parameter int NUM_PAGES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [31:0] address,
	input  wire logic [31:0] byte_count,
	input  wire logic [4:0]  align_shift,
	input  wire logic        do_commit,
	input  wire logic        top_down,
	input  wire logic        do_reserve,
	input  wire logic [31:0] protect_flags,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [31:0]      result_address,
	output logic [31:0]      result_bytes,
	output logic [31:0]      run_alloc_base,
	output logic [31:0]      run_alloc_protect,
	output logic [1:0]       run_state,
	output logic [31:0]      run_protect,
	output logic             was_committed
);
	import prca_pkg::*;

	localparam int AW = $clog2(NUM_PAGES);
	localparam int CW = $clog2(NUM_PAGES + 1);

	cfg_t            cfg_q;
	req_t            req;
	result_t         seq_res, out_q;
	logic            seq_res_valid, res_ready, out_valid_q;
	logic [AW-1:0]   tbl_addr;
	tbl_wr_t         tbl_wr;
	logic [CW-1:0]   tbl_wd_b, tbl_rd_b;
	page_ent_t       tbl_rd_a;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_base  <= 32'd0;
			cfg_q.page_shift <= PS_MIN;
			cfg_q.min_align  <= PS_MIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEAP_BASE:  cfg_q.heap_base  <= cfg_data;
				CFG_PAGE_SHIFT: cfg_q.page_shift <= cfg_data[4:0];
				CFG_MIN_ALIGN:  cfg_q.min_align  <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	assign req = '{mode: mode, address: address, byte_count: byte_count,
		align_shift: align_shift, do_commit: do_commit, top_down: top_down,
		do_reserve: do_reserve, protect_flags: protect_flags};

	prca_seq #(.NUM_PAGES(NUM_PAGES)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req       (req),
		.res_valid (seq_res_valid),
		.res_ready (res_ready),
		.res       (seq_res),
		.tbl_addr  (tbl_addr),
		.tbl_wr    (tbl_wr),
		.tbl_wd_b  (tbl_wd_b),
		.tbl_rd_a  (tbl_rd_a),
		.tbl_rd_b  (tbl_rd_b)
	);

	prca_table #(.NUM_PAGES(NUM_PAGES)) u_table (
		.clk  (clk),
		.addr (tbl_addr),
		.wr   (tbl_wr),
		.wd_b (tbl_wd_b),
		.rd_a (tbl_rd_a),
		.rd_b (tbl_rd_b)
	);

	// The output register takes a new result whenever it is empty or being transferred.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res_valid && res_ready) begin
			out_q <= seq_res;
		end
	end

	assign out_valid         = out_valid_q;
	assign ok                = out_q.ok;
	assign result_address    = out_q.addr;
	assign result_bytes      = out_q.bytes;
	assign run_alloc_base    = out_q.abase;
	assign run_alloc_protect = out_q.aprot;
	assign run_state         = out_q.st;
	assign run_protect       = out_q.prot;
	assign was_committed     = out_q.wc;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block took a second item while the first was in progress");

	a_fail_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (result_address == 32'd0 && result_bytes == 32'd0))
		else $error("failed operation carries an address or a size");

	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok) |-> (run_state != 2'd3))
		else $error("result reports a page status that is never stored");

endmodule

`default_nettype wire
